FILE: rtl/gmdc_pkg.sv
`default_nettype none

package gmdc_pkg;

    // Sizing of the kept set and of one codeword.
    localparam int MAX_KEPT    = 256;
    localparam int MAX_SYMBOLS = 16;
    localparam int WORD_W      = 32;
    localparam int SYM_LANES   = WORD_W / 2;
    localparam int ADDR_W      = $clog2(MAX_KEPT);
    localparam int CNT_W       = $clog2(MAX_KEPT + 1);
    localparam int DIST_W      = $clog2(SYM_LANES + 1);

    // Fixed field widths of the item interfaces.
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CIDX_W     = 8;
    localparam int KCOUNT_W   = 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_IN_USE = 2'd1;

    typedef struct packed {
        logic [WORD_W-1:0] candidate_word;
        logic              start_new;
    } in_t;

    typedef struct packed {
        logic                accepted;
        logic                conflict_found;
        logic [CIDX_W-1:0]   conflict_index;
        logic                overflow;
        logic [KCOUNT_W-1:0] kept_count;
    } out_t;

    // Settings handed from the register file to the filter core.
    typedef struct packed {
        logic [CFG_W-1:0] min_distance;
        logic [CFG_W-1:0] symbols_in_use;
    } cfg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/gmdc_core.sv
`default_nettype none

module gmdc_core
    import gmdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    // Kept codeword store, one read or one write per cycle.
    logic [WORD_W-1:0] kept_mem [MAX_KEPT];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] word_reg;
    logic              conflict_reg, conflict_next;
    logic [ADDR_W-1:0] cidx_reg, cidx_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg, out_data_next;

    logic              in_fire;
    logic              issue;
    logic              hit;
    logic              finish;
    logic              wr_en;
    logic [SYM_LANES-1:0] lane_on;
    logic [SYM_LANES-1:0] lane_diff;
    logic [DIST_W-1:0]    mismatches;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Lanes taking part in the compare, limited to the supported symbols.
    always_comb
    begin
        for (int i = 0; i < SYM_LANES; i++)
        begin
            lane_on[i] = (i < int'(cfg.symbols_in_use)) && (i < MAX_SYMBOLS);
        end
    end

    // Symbol mismatch count between the candidate and the word just read.
    always_comb
    begin
        mismatches = '0;
        for (int i = 0; i < SYM_LANES; i++)
        begin
            lane_diff[i] = lane_on[i] && ((word_reg[2*i+1] ^ rd_data_reg[2*i+1])
                                       || (word_reg[2*i] ^ rd_data_reg[2*i]));
            mismatches = mismatches + DIST_W'(lane_diff[i]);
        end
    end

    assign hit   = rd_valid_reg && (mismatches < cfg.min_distance);
    assign issue = (state_reg == S_SCAN) && (issue_reg < total_reg) && !hit;

    // Next state and result assembly.
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        issue_next     = issue_reg;
        rd_valid_next  = issue;
        conflict_next  = conflict_reg;
        cidx_next      = cidx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        finish         = 1'b0;
        wr_en          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.start_new)
                    begin
                        total_next = '0;
                    end
                    issue_next    = '0;
                    conflict_next = 1'b0;
                    cidx_next     = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (hit)
                begin
                    conflict_next = 1'b1;
                    cidx_next     = rd_idx_reg;
                    state_next    = S_DONE;
                end
                else if (!issue && !rd_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold here until the output register can take the result.
                if (!out_valid_reg || out_ready)
                begin
                    finish = 1'b1;
                    out_data_next.accepted       = 1'b0;
                    out_data_next.conflict_found = conflict_reg;
                    out_data_next.conflict_index =
                        conflict_reg ? CIDX_W'(cidx_reg) : '0;
                    out_data_next.overflow       = 1'b0;
                    if (!conflict_reg)
                    begin
                        if (total_reg < CNT_W'(MAX_KEPT))
                        begin
                            wr_en                  = 1'b1;
                            total_next             = total_reg + 1'b1;
                            out_data_next.accepted = 1'b1;
                        end
                        else
                        begin
                            out_data_next.overflow = 1'b1;
                        end
                    end
                    out_data_next.kept_count = KCOUNT_W'(total_next);
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            conflict_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            conflict_reg  <= conflict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cidx_reg     <= cidx_next;
        out_data_reg <= out_data_next;
        if (in_fire)
        begin
            word_reg <= in_data.candidate_word;
        end
    end

    // Store port: reads during the scan, the append once the scan is over.
    // The append happens only in the done state and no read is issued
    // there, so a read and a write never meet on the same entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kept_mem[total_reg[ADDR_W-1:0]] <= word_reg;
        end
        if (issue)
        begin
            rd_data_reg <= kept_mem[issue_reg[ADDR_W-1:0]];
            rd_idx_reg  <= issue_reg[ADDR_W-1:0];
        end
    end

    // The kept count never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count beyond store depth");

    // Reads never run past the kept words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= total_reg))
        else $error("scan read past kept words");

    // No read is in flight when a new item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rd_valid_reg)
        else $error("read still in flight while idle");

    // A new result reports exactly one outcome class.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $onehot({out_data_reg.accepted, out_data_reg.conflict_found,
                     out_data_reg.overflow}))
        else $error("result outcome flags inconsistent");

    // An appended word is counted in the reported total.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && finish) |=>
            (out_data_reg.kept_count == KCOUNT_W'(total_reg)))
        else $error("reported count differs from kept total");

endmodule

`default_nettype wire

FILE: rtl/greedy_min_distance_code_filter_top.sv
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------
// in       | input     | in_valid / in_ready  | in_data (candidate, start_new)
// out      | output    | out_valid / out_ready| out_data (one result per item)
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Without a conflict an item reads all N kept words before its result, N being
// the number of kept words; a conflict at index k ends the scan there. The
// memory gives one word per cycle to the distance compare.
// Reset empties the kept set and loads min_distance 3 and symbols_in_use 16.
// A result waits in the output register while the next item is accepted; a
// stalled output holds the core in its done state.

module greedy_min_distance_code_filter_top
    import gmdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_t                      out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] min_distance_reg;
    logic [CFG_W-1:0] symbols_in_use_reg;
    cfg_t             cfg;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg   <= CFG_W'(3);
            symbols_in_use_reg <= CFG_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_DISTANCE:   min_distance_reg   <= cfg_data;
                REG_SYMBOLS_IN_USE: symbols_in_use_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg.min_distance   = min_distance_reg;
    assign cfg.symbols_in_use = symbols_in_use_reg;

    // Filter core with the kept-word memory.
    gmdc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
